>>> hw/rtl/uct_child_select_core_defines.svh
// Assertion macros for the UCT child selection block.
// Included by the top level only; no other dependencies.
`ifndef UCT_CHILD_SELECT_CORE_DEFINES_SVH
`define UCT_CHILD_SELECT_CORE_DEFINES_SVH
`ifndef SYNTH
`define UCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ucs assertion failed");
`define UCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ucs assertion failed");
`else
`define UCS_ASSERT_IMP(lbl, ante, cons)
`define UCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/ucs_pkg.sv
// Shared types and constants of the UCT child selection block.
// No dependencies.
package ucs_pkg;

  localparam logic [15:0] WeightRst = 16'd5775;
  localparam logic [15:0] Ln2Q16    = 16'd45426;
  localparam logic [31:0] ScoreMax  = 32'h7FFF_FFFF;
  localparam logic [31:0] ScoreMin  = 32'h8000_0000;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LN    = 6'b000010,
    S_RATIO = 6'b000100,
    S_SQRT  = 6'b001000,
    S_MUL   = 6'b010000,
    S_UPD   = 6'b100000
  } state_e;

endpackage

>>> hw/rtl/ucs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Divides a W-bit unsigned dividend by a 24-bit nonzero divisor. No dependencies.
module ucs_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [23:0]  divisor_i,
  output logic         busy_o,
  output logic [W-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    quo_q, quo_d;
  logic [23:0]     rem_q, rem_d;
  logic [23:0]     dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [24:0]     rem_sh, diff;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[W-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? diff[23:0] : rem_sh[23:0];
    quo_d  = {quo_q[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

>>> hw/rtl/ucs_ln.sv
// Natural logarithm in Q5.16: one fraction bit of log2 per cycle by
// repeated squaring, then a scale by ln 2. Depends on ucs_pkg.
module ucs_ln
  import ucs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] parent_i,
  output logic        busy_o,
  output logic [20:0] ln_o
);

  logic [31:0] m_q;
  logic [4:0]  k_q;
  logic [15:0] frac_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [20:0] ln_q;
  logic [23:0] p0;
  logic [4:0]  k_d;
  logic [63:0] prod;
  logic [32:0] sq;
  logic [36:0] ln_prod;

  always_comb begin
    p0  = (parent_i == '0) ? 24'd1 : parent_i;
    k_d = '0;
    for (int i = 0; i < 24; i++) begin
      if (p0[i]) begin
        k_d = 5'(i);
      end
    end
    prod    = 64'(m_q) * 64'(m_q);
    sq      = prod[63:31];
    ln_prod = 37'({k_q, frac_q}) * 37'(Ln2Q16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd17;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == 5'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q    <= 32'(p0) << (5'd31 - k_d);
      k_q    <= k_d;
      frac_q <= '0;
    end else if (busy_q) begin
      if (cnt_q > 5'd1) begin
        frac_q <= {frac_q[14:0], sq[32]};
        m_q    <= sq[32] ? sq[32:1] : sq[31:0];
      end else begin
        ln_q <= ln_prod[36:16];
      end
    end
  end

  assign busy_o = busy_q;
  assign ln_o   = ln_q;

endmodule

>>> hw/rtl/ucs_sqrt.sv
// Integer square root, one root bit per cycle (two radicand bits per step).
// 38-bit radicand, 19-bit root. No dependencies.
module ucs_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [37:0] rad_i,
  output logic        busy_o,
  output logic [18:0] root_o
);

  logic [37:0] rad_q;
  logic [20:0] rem_q;
  logic [18:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [22:0] rem_sh, trial, diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, rad_q[37:36]};
    trial  = {2'b00, root_q, 2'b01};
    diff   = rem_sh - trial;
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd19;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == 5'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[35:0], 2'b00};
      rem_q  <= ge ? diff[20:0] : rem_sh[20:0];
      root_q <= {root_q[17:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

>>> hw/rtl/uct_child_select_core.sv
// UCB1 child selection for one search-tree node, Q16.16 fixed point.
// Usage:
//   The children of a node arrive as requests on the input channel (valid and
//   stall), one child per request, the final one marked by last_child_i.
//   Each visited child is scored as reward/visits + C*sqrt(ln(parent)/visits);
//   an unvisited child scores as infinity and the first maximum is kept.
//   After the final child one request leaves on the output channel with the
//   winning index, its score and the unvisited flag.
// Sequence:
//   For a visited child the log unit, the ratio divider and the square root
//   run in series with handoff, multiply and update steps around them, while
//   the mean divider runs beside them; the next child is accepted only after
//   the update step. A skipped child (unvisited, past the child limit, or after
//   an unvisited winner) goes from acceptance straight to the update step.
// Reset clears the running best, the child count and the output valid flag, and
// sets the exploration weight to 1.41 in Q4.12. Write the weight register through
// cfg_we_i only while the block is idle; the block itself does not enforce this.
// A stalled output holds its request; the block still takes the next children
// and waits only if another node result is ready before the slot frees.
// Depends on ucs_pkg, ucs_div, ucs_ln, ucs_sqrt and the defines header.
`include "uct_child_select_core_defines.svh"

module uct_child_select_core
  import ucs_pkg::*;
#(
  parameter int unsigned MAX_CHILDREN = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] child_reward_i,
  input  logic [23:0]        child_visits_i,
  input  logic [23:0]        parent_visits_i,
  input  logic               last_child_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         best_index_o,
  output logic signed [31:0] best_score_o,
  output logic               best_unvisited_o
);

  localparam int unsigned CntW = $clog2(MAX_CHILDREN + 1);

  state_e state_q, state_d;

  logic [15:0]     weight_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0]     best_q;
  logic [7:0]      idx_q;
  logic            inf_q;

  // Per-child context captured at acceptance; explore_q is set in the multiply step.
  logic        last_q, unv_q, full_q, sign_q;
  logic [23:0] visits_q;
  logic [22:0] explore_q;

  logic        out_valid_q;
  logic [7:0]  out_idx_q;
  logic [31:0] out_score_q;
  logic        out_inf_q;

  logic        accept, full_now, unv_now, skip_now;
  logic        mdiv_busy, rdiv_busy, ln_busy, sqrt_busy;
  logic [31:0] mean_quot, reward_mag;
  logic [20:0] ln_val, ratio;
  logic [18:0] root;
  logic        ln_start, rdiv_start, sqrt_start;
  logic [34:0] explore_prod;
  logic [32:0] mean;
  logic [33:0] sum;
  logic [31:0] score;
  logic        beat, take_inf, upd_go;
  logic        out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign full_now   = (cnt_q == CntW'(MAX_CHILDREN));
  assign unv_now    = (child_visits_i == '0);
  assign skip_now   = full_now || unv_now || inf_q;
  assign ln_start   = accept && !skip_now;
  assign reward_mag = child_reward_i[31] ? (32'd0 - 32'(child_reward_i))
                                         : 32'(child_reward_i);

  ucs_div #(.W(32)) u_mean_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ln_start),
    .dividend_i (reward_mag),
    .divisor_i  (child_visits_i),
    .busy_o     (mdiv_busy),
    .quot_o     (mean_quot)
  );

  ucs_ln u_ln (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ln_start),
    .parent_i (parent_visits_i),
    .busy_o   (ln_busy),
    .ln_o     (ln_val)
  );

  assign rdiv_start = (state_q == S_LN) && !ln_busy;

  ucs_div #(.W(21)) u_ratio_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rdiv_start),
    .dividend_i (ln_val),
    .divisor_i  (visits_q),
    .busy_o     (rdiv_busy),
    .quot_o     (ratio)
  );

  assign sqrt_start = (state_q == S_RATIO) && !rdiv_busy;

  ucs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   ({1'b0, ratio, 16'd0}),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  // Score assembly: signed mean plus the nonnegative exploration term,
  // saturated at the largest positive value.
  always_comb begin
    explore_prod = 35'(weight_q) * 35'(root);
    mean  = sign_q ? (33'd0 - {1'b0, mean_quot}) : {1'b0, mean_quot};
    sum   = {mean[32], mean} + {11'd0, explore_q};
    score = (!sum[33] && (sum[32:31] != 2'b00)) ? ScoreMax : sum[31:0];
    take_inf = !full_q && unv_q && !inf_q;
    beat     = !full_q && !unv_q && !inf_q && ($signed(score) > $signed(best_q));
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign upd_go   = (state_q == S_UPD) && (!last_q || out_free);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = skip_now ? S_UPD : S_LN;
        end
      end
      S_LN: begin
        if (!ln_busy) begin
          state_d = S_RATIO;
        end
      end
      S_RATIO: begin
        if (!rdiv_busy) begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!sqrt_busy && !mdiv_busy) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (upd_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      weight_q    <= WeightRst;
      cnt_q       <= '0;
      best_q      <= ScoreMin;
      idx_q       <= '0;
      inf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        weight_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (upd_go) begin
        if (last_q) begin
          // The node ends here: publish including this child, then clear.
          out_valid_q <= 1'b1;
          cnt_q       <= '0;
          best_q      <= ScoreMin;
          idx_q       <= '0;
          inf_q       <= 1'b0;
        end else begin
          if (!full_q) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (take_inf) begin
            inf_q  <= 1'b1;
            best_q <= ScoreMax;
            idx_q  <= 8'(cnt_q);
          end else if (beat) begin
            best_q <= score;
            idx_q  <= 8'(cnt_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q   <= last_child_i;
      unv_q    <= unv_now;
      full_q   <= full_now;
      sign_q   <= child_reward_i[31];
      visits_q <= child_visits_i;
    end
    if (state_q == S_MUL) begin
      explore_q <= explore_prod[34:12];
    end
    if (upd_go && last_q) begin
      if (take_inf) begin
        out_idx_q   <= 8'(cnt_q);
        out_score_q <= ScoreMax;
        out_inf_q   <= 1'b1;
      end else if (beat) begin
        out_idx_q   <= 8'(cnt_q);
        out_score_q <= score;
        out_inf_q   <= inf_q;
      end else begin
        out_idx_q   <= idx_q;
        out_score_q <= best_q;
        out_inf_q   <= inf_q;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign best_index_o     = out_idx_q;
  assign best_score_o     = out_score_q;
  assign best_unvisited_o = out_inf_q;

  // A new result appears only out of the update step of a final child.
  `UCS_ASSERT_IMP(a_result_source, $rose(out_valid_q), $past(state_q == S_UPD && last_q))
  // Closing a node leaves the running state cleared for the next one.
  `UCS_ASSERT_NEXT(a_node_clear, upd_go && last_q, cnt_q == '0 && !inf_q)
  // An unvisited winner always carries the saturated score.
  `UCS_ASSERT_IMP(a_inf_score, inf_q, best_q == ScoreMax)

endmodule
